// ----- src/assert_macros.svh -----
// Assertion macros for the port-level checker of the palette allocator.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define CTQP_ASSERT_NOW(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("ctqp: assertion failed");

// Next-cycle implication, disabled during reset.
`define CTQP_ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("ctqp: assertion failed");

`endif

// ----- src/ctqp_pkg.sv -----
// Types and constants for the palette allocator (color table, quadratic probing).
// No dependencies; used by the sequencer, the top level and the checker.
`default_nettype none

package ctqp_pkg;

    localparam int TABLE_DEPTH_DEF = 256;

    localparam int SIZE_W   = 9;
    localparam int LEVEL_W  = 8;
    localparam int COLOR_W  = 3 * LEVEL_W;
    localparam int HASH_W   = 16;
    localparam int HCNT_W   = $clog2(HASH_W);
    localparam int SLOT_W   = 8;
    localparam int STATUS_W = 3;
    localparam int UPC_W    = 5;

    localparam int APB_AW    = 3;
    localparam int APB_DW    = 32;
    localparam int REG_IDX_W = APB_AW - 2;

    localparam logic [REG_IDX_W-1:0] REG_TABLE_SIZE = 1'b0;

    localparam logic [STATUS_W-1:0] ST_FOUND    = 3'd0;
    localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NO_TABLE = 3'd3;
    localparam logic [STATUS_W-1:0] ST_CLEARED  = 3'd4;

    localparam logic ACT_LOOKUP = 1'b0;
    localparam logic ACT_CLEAR  = 1'b1;

    localparam logic [HASH_W-1:0] HASH_KR = 16'd67;
    localparam logic [HASH_W-1:0] HASH_KG = 16'd59;
    localparam logic [HASH_W-1:0] HASH_KB = 16'd71;

    typedef struct packed {
        logic               action;
        logic [LEVEL_W-1:0] red_level;
        logic [LEVEL_W-1:0] green_level;
        logic [LEVEL_W-1:0] blue_level;
    } t_in_item;

    typedef struct packed {
        logic [SLOT_W-1:0]   slot_index;
        logic [STATUS_W-1:0] status;
    } t_out_item;

    // Branch condition selected by a microcode word.
    typedef enum logic [3:0] {
        C_ALWAYS,
        C_CLR_MORE,
        C_OUT_BUSY,
        C_NO_ACCEPT,
        C_ACTION,
        C_NO_TABLE,
        C_DIV_MORE,
        C_SIZE_ONE,
        C_EMPTY,
        C_MATCH,
        C_K_MORE
    } t_cond_sel;

    // Datapath status seen by the sequencer.
    typedef struct packed {
        logic clr_more;
        logic out_busy;
        logic no_accept;
        logic action;
        logic no_table;
        logic div_more;
        logic size_one;
        logic empty;
        logic match;
        logic k_more;
    } t_flags;

    // One microcode word.
    typedef struct packed {
        logic                in_ready;
        logic                clr_wr;
        logic                div_init;
        logic                div_step;
        logic                pr_init;
        logic                pr_step;
        logic                ins_wr;
        logic                st_load;
        logic [STATUS_W-1:0] st_code;
        logic                st_idx;
        logic                out_load;
        t_cond_sel           cond;
        logic [UPC_W-1:0]    target;
    } t_ctrl;

endpackage

`default_nettype wire

// ----- src/ctqp_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module ctqp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ----- src/ctqp_seq.sv -----
// Microcode sequencer: step counter, control store and conditional branch.
// Depends on ctqp_pkg.
`default_nettype none

module ctqp_seq (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire ctqp_pkg::t_flags i_flags,
    output ctqp_pkg::t_ctrl      o_ctrl
);
    import ctqp_pkg::*;

    localparam logic [UPC_W-1:0] UA_RST_CLR   = 5'd0;
    localparam logic [UPC_W-1:0] UA_RST_END   = 5'd1;
    localparam logic [UPC_W-1:0] UA_EMIT      = 5'd2;
    localparam logic [UPC_W-1:0] UA_IDLE      = 5'd3;
    localparam logic [UPC_W-1:0] UA_DISPATCH  = 5'd4;
    localparam logic [UPC_W-1:0] UA_SIZE      = 5'd5;
    localparam logic [UPC_W-1:0] UA_DIV       = 5'd6;
    localparam logic [UPC_W-1:0] UA_PR_INIT   = 5'd7;
    localparam logic [UPC_W-1:0] UA_CHK_EMPTY = 5'd8;
    localparam logic [UPC_W-1:0] UA_CHK_MATCH = 5'd9;
    localparam logic [UPC_W-1:0] UA_ADVANCE   = 5'd10;
    localparam logic [UPC_W-1:0] UA_FULL      = 5'd11;
    localparam logic [UPC_W-1:0] UA_CLR       = 5'd12;
    localparam logic [UPC_W-1:0] UA_CLR_END   = 5'd13;
    localparam logic [UPC_W-1:0] UA_NOTAB     = 5'd14;
    localparam logic [UPC_W-1:0] UA_INSERT    = 5'd15;
    localparam logic [UPC_W-1:0] UA_FOUND     = 5'd16;

    // Control store. A word branches to target when its condition holds,
    // otherwise falls through to the next step.
    function automatic t_ctrl ucode(input logic [UPC_W-1:0] addr);
        t_ctrl w;
        w        = '0;
        w.cond   = C_ALWAYS;
        w.target = UA_IDLE;
        case (addr)
            UA_RST_CLR: begin
                w.clr_wr = 1'b1;
                w.cond   = C_CLR_MORE;
                w.target = UA_RST_CLR;
            end
            UA_RST_END: begin
                w.target = UA_IDLE;
            end
            UA_EMIT: begin
                w.out_load = 1'b1;
                w.cond     = C_OUT_BUSY;
                w.target   = UA_EMIT;
            end
            UA_IDLE: begin
                w.in_ready = 1'b1;
                w.cond     = C_NO_ACCEPT;
                w.target   = UA_IDLE;
            end
            UA_DISPATCH: begin
                w.cond   = C_ACTION;
                w.target = UA_CLR;
            end
            UA_SIZE: begin
                w.div_init = 1'b1;
                w.cond     = C_NO_TABLE;
                w.target   = UA_NOTAB;
            end
            UA_DIV: begin
                w.div_step = 1'b1;
                w.cond     = C_DIV_MORE;
                w.target   = UA_DIV;
            end
            UA_PR_INIT: begin
                w.pr_init = 1'b1;
                w.cond    = C_SIZE_ONE;
                w.target  = UA_FULL;
            end
            UA_CHK_EMPTY: begin
                w.cond   = C_EMPTY;
                w.target = UA_INSERT;
            end
            UA_CHK_MATCH: begin
                w.cond   = C_MATCH;
                w.target = UA_FOUND;
            end
            UA_ADVANCE: begin
                w.pr_step = 1'b1;
                w.cond    = C_K_MORE;
                w.target  = UA_CHK_EMPTY;
            end
            UA_FULL: begin
                w.st_load = 1'b1;
                w.st_code = ST_FULL;
                w.target  = UA_EMIT;
            end
            UA_CLR: begin
                w.clr_wr = 1'b1;
                w.cond   = C_CLR_MORE;
                w.target = UA_CLR;
            end
            UA_CLR_END: begin
                w.st_load = 1'b1;
                w.st_code = ST_CLEARED;
                w.target  = UA_EMIT;
            end
            UA_NOTAB: begin
                w.st_load = 1'b1;
                w.st_code = ST_NO_TABLE;
                w.target  = UA_EMIT;
            end
            UA_INSERT: begin
                w.ins_wr  = 1'b1;
                w.st_load = 1'b1;
                w.st_code = ST_INSERTED;
                w.st_idx  = 1'b1;
                w.target  = UA_EMIT;
            end
            UA_FOUND: begin
                w.st_load = 1'b1;
                w.st_code = ST_FOUND;
                w.st_idx  = 1'b1;
                w.target  = UA_EMIT;
            end
            default: begin
                w.target = UA_IDLE;
            end
        endcase
        return w;
    endfunction

    logic [UPC_W-1:0] r_upc;
    logic [UPC_W-1:0] n_upc;
    t_ctrl            ctrl;
    logic             take;

    always_comb begin
        ctrl = ucode(r_upc);
        case (ctrl.cond)
            C_ALWAYS:    take = 1'b1;
            C_CLR_MORE:  take = i_flags.clr_more;
            C_OUT_BUSY:  take = i_flags.out_busy;
            C_NO_ACCEPT: take = i_flags.no_accept;
            C_ACTION:    take = i_flags.action;
            C_NO_TABLE:  take = i_flags.no_table;
            C_DIV_MORE:  take = i_flags.div_more;
            C_SIZE_ONE:  take = i_flags.size_one;
            C_EMPTY:     take = i_flags.empty;
            C_MATCH:     take = i_flags.match;
            C_K_MORE:    take = i_flags.k_more;
            default:     take = 1'b1;
        endcase
        n_upc = take ? ctrl.target : r_upc + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc <= UA_RST_CLR;
        end else begin
            r_upc <= n_upc;
        end
    end

    assign o_ctrl = ctrl;

endmodule

`default_nettype wire

// ----- src/color_table_quadratic_probe.sv -----
// Palette allocator: open-addressing hash table with quadratic probing over
// 24-bit colors, one result per item. After reset a clearing pass runs
// before the first item is taken. The home slot is reduced modulo the table
// size by a one-bit-per-cycle divider, and each probe is a read of the slot
// RAM followed by an empty check and a color compare. A lookup ends by
// inserting, by a hit, by running out of probes, or with no table. A clear
// item sweeps the slot RAM one entry per cycle. The next item is taken as
// soon as the result sits in the output register; a stalled result holds the
// block at that point.
// Depends on ctqp_pkg, ctqp_seq and ctqp_ram.
`default_nettype none

module color_table_quadratic_probe #(
    parameter int TABLE_DEPTH = ctqp_pkg::TABLE_DEPTH_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire ctqp_pkg::t_in_item            i_in_item,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output ctqp_pkg::t_out_item                o_out_item,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [ctqp_pkg::APB_AW-1:0]   paddr,
    input  wire logic [ctqp_pkg::APB_DW-1:0]   pwdata,
    output logic      [ctqp_pkg::APB_DW-1:0]   prdata,
    output logic                               pready
);
    import ctqp_pkg::*;

    localparam int AW    = $clog2(TABLE_DEPTH);
    localparam int RAM_W = COLOR_W + 1;
    localparam logic [AW-1:0] LAST_ENTRY = AW'(TABLE_DEPTH - 1);

    function automatic logic [HASH_W-1:0] color_hash(input t_in_item it);
        return HASH_W'(it.red_level) * HASH_KR + HASH_W'(it.green_level) * HASH_KG
             + HASH_W'(it.blue_level) * HASH_KB;
    endfunction

    t_ctrl  ctrl;
    t_flags flags;

    // Configuration
    logic [SIZE_W-1:0] r_table_size;
    logic [SIZE_W-1:0] eff_size;
    logic              cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready
                  & (paddr[APB_AW-1:2] == REG_TABLE_SIZE);
    assign prdata = (paddr[APB_AW-1:2] == REG_TABLE_SIZE) ? APB_DW'(r_table_size) : '0;
    assign eff_size = (32'(r_table_size) > TABLE_DEPTH) ? SIZE_W'(TABLE_DEPTH)
                                                        : r_table_size;

    // Input latch
    logic               in_acc;
    logic               r_action;
    logic [COLOR_W-1:0] r_color;
    logic [HASH_W-1:0]  r_hash;

    assign o_in_stall = !ctrl.in_ready;
    assign in_acc     = i_in_valid & ctrl.in_ready;

    // Restoring division of the hash by the table size
    logic [HCNT_W-1:0] r_div_cnt;
    logic [SIZE_W-1:0] r_rem;
    logic [SIZE_W:0]   size_x;
    logic [SIZE_W:0]   div_trial;
    logic [SIZE_W:0]   div_sub;
    logic [SIZE_W-1:0] rem_next;

    assign size_x    = {1'b0, eff_size};
    assign div_trial = {r_rem, r_hash[r_div_cnt]};
    assign div_sub   = div_trial - size_x;
    assign rem_next  = (div_trial >= size_x) ? div_sub[SIZE_W-1:0] : div_trial[SIZE_W-1:0];

    // Probe walk: slot advances by 2k-1 each probe, both kept below the size
    logic [SIZE_W-1:0] r_slot, n_slot;
    logic [SIZE_W-1:0] r_step, n_step;
    logic [SIZE_W-1:0] r_k, n_k;
    logic [SIZE_W:0]   slot_sum, slot_red;
    logic [SIZE_W:0]   step_sum, step_red;
    logic [SIZE_W:0]   k_inc;

    assign slot_sum = {1'b0, r_slot} + {1'b0, r_step};
    assign slot_red = (slot_sum >= size_x) ? slot_sum - size_x : slot_sum;
    assign step_sum = {1'b0, r_step} + (SIZE_W+1)'(2);
    assign step_red = (step_sum >= size_x) ? step_sum - size_x : step_sum;
    assign k_inc    = {1'b0, r_k} + 1'b1;

    always_comb begin
        n_slot = r_slot;
        n_step = r_step;
        n_k    = r_k;
        if (ctrl.pr_init) begin
            n_slot = r_rem;
            n_step = SIZE_W'(1);
            n_k    = SIZE_W'(1);
        end else if (ctrl.pr_step) begin
            n_slot = slot_red[SIZE_W-1:0];
            n_step = step_red[SIZE_W-1:0];
            n_k    = k_inc[SIZE_W-1:0];
        end
    end

    // Slot RAM: {valid, color}. Read address follows the next slot so the
    // read data always belongs to r_slot.
    logic [AW-1:0]    r_clr_cnt;
    logic             ram_we;
    logic [AW-1:0]    ram_waddr;
    logic [RAM_W-1:0] ram_wdata;
    logic [RAM_W-1:0] ram_rdata;

    assign ram_we    = ctrl.clr_wr | ctrl.ins_wr;
    assign ram_waddr = ctrl.clr_wr ? r_clr_cnt : AW'(r_slot);
    assign ram_wdata = ctrl.clr_wr ? '0 : {1'b1, r_color};

    ctqp_ram #(
        .WIDTH (RAM_W),
        .DEPTH (TABLE_DEPTH)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (AW'(n_slot)),
        .o_rdata (ram_rdata)
    );

    // Result and output register
    logic [STATUS_W-1:0] r_res_status;
    logic [SLOT_W-1:0]   r_res_slot;
    logic                r_out_valid;
    t_out_item           r_out_item;
    logic                out_busy;
    logic                out_fire;

    assign out_busy = r_out_valid & i_out_stall;
    assign out_fire = ctrl.out_load & !out_busy;

    always_comb begin
        flags.clr_more  = (r_clr_cnt != LAST_ENTRY);
        flags.out_busy  = out_busy;
        flags.no_accept = !i_in_valid;
        flags.action    = (r_action == ACT_CLEAR);
        flags.no_table  = (eff_size == '0);
        flags.div_more  = (r_div_cnt != '0);
        flags.size_one  = (eff_size == SIZE_W'(1));
        flags.empty     = !ram_rdata[COLOR_W];
        flags.match     = (ram_rdata[COLOR_W-1:0] == r_color);
        flags.k_more    = (k_inc < size_x);
    end

    ctqp_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flags (flags),
        .o_ctrl  (ctrl)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_table_size <= '0;
            r_clr_cnt    <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (cfg_wr) begin
                r_table_size <= pwdata[SIZE_W-1:0];
            end
            if (ctrl.clr_wr) begin
                r_clr_cnt <= (r_clr_cnt == LAST_ENTRY) ? '0 : r_clr_cnt + 1'b1;
            end
            if (out_fire) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_action <= i_in_item.action;
            r_color  <= {i_in_item.red_level, i_in_item.green_level, i_in_item.blue_level};
            r_hash   <= color_hash(i_in_item);
        end
        if (ctrl.div_init) begin
            r_rem     <= '0;
            r_div_cnt <= HCNT_W'(HASH_W - 1);
        end else if (ctrl.div_step) begin
            r_rem     <= rem_next;
            r_div_cnt <= r_div_cnt - 1'b1;
        end
        r_slot <= n_slot;
        r_step <= n_step;
        r_k    <= n_k;
        if (ctrl.st_load) begin
            r_res_status <= ctrl.st_code;
            r_res_slot   <= ctrl.st_idx ? r_slot[SLOT_W-1:0] : '0;
        end
        if (out_fire) begin
            r_out_item.slot_index <= r_res_slot;
            r_out_item.status     <= r_res_status;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

`default_nettype wire

// ----- src/ctqp_checker.sv -----
// Port-level checks of the palette allocator, bound to the top level.
// Depends on ctqp_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module ctqp_checker (
    input wire logic                        i_clk,
    input wire logic                        i_rst_n,
    input wire logic                        i_in_valid,
    input wire logic                        o_in_stall,
    input wire logic                        o_out_valid,
    input wire logic                        i_out_stall,
    input wire ctqp_pkg::t_out_item         o_out_item
);
    import ctqp_pkg::*;

    // A stalled result stays put.
    `CTQP_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_item))

    // The block is busy right after taking a transfer.
    `CTQP_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall)

    // Only found and inserted results carry a slot.
    `CTQP_ASSERT_NOW(a_idx_zero, i_clk, i_rst_n, o_out_valid && o_out_item.status != ST_FOUND && o_out_item.status != ST_INSERTED, o_out_item.slot_index == '0)

    // A new result appears only while the input side is held off.
    `CTQP_ASSERT_NOW(a_result_while_busy, i_clk, i_rst_n, $rose(o_out_valid), $past(o_in_stall))

endmodule

bind color_table_quadratic_probe ctqp_checker u_ctqp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_item  (o_out_item)
);

`default_nettype wire
